// File: rtl/first_fit_region_allocator_assert.svh
// assertion macros used by the allocator datapath
`ifndef FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_REGION_ALLOCATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define FFRA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define FFRA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define FFRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/ffra_pkg.sv
package ffra_pkg;

   localparam int unsigned     FFRA_MAX_REGIONS  = 32;
   localparam int unsigned     FFRA_ALIGN        = 16;
   localparam longint unsigned FFRA_POOL_MAX     = 64'd65536;
   localparam longint unsigned FFRA_OFFSET_REACH = 64'd65536;

   localparam int unsigned POOL_W   = 17;
   localparam int unsigned FIELD_W  = 17;
   localparam int unsigned OFFSET_W = 16;
   localparam int unsigned SUM_W    = 18;
   localparam int unsigned CUR_W    = 18;
   localparam int unsigned NEED_W   = 19;

   typedef enum logic [2:0] {
      STATUS_OK         = 3'd0,
      STATUS_NO_SPACE   = 3'd1,
      STATUS_TABLE_FULL = 3'd2,
      STATUS_NOT_FOUND  = 3'd3,
      STATUS_ZERO_SIZE  = 3'd4
   } status_type;

   typedef enum logic {
      MODE_ALLOC = 1'b0,
      MODE_FREE  = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type            mode;
      logic [16:0]         request_size;
      logic [OFFSET_W-1:0] free_offset;
   } ffra_req_type;

   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] region_offset;
   } ffra_rsp_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_CHECK,
      CTL_SIZE,
      CTL_SCAN,
      CTL_INSERT,
      CTL_REMOVE,
      CTL_DONE
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_SCAN_START,
      OP_SCAN_NEXT,
      OP_INS_START,
      OP_INS_STEP,
      OP_INS_PLACE,
      OP_REM_START,
      OP_REM_STEP,
      OP_REM_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       rsp_load;
      status_type rsp_status;
   } ffra_cmd_type;

   typedef struct packed {
      logic is_free;
      logic req_zero;
      logic table_full;
      logic at_end;
      logic fit;
      logic end_fit;
      logic match;
      logic sh_at_pos;
      logic sh_at_last;
      logic rsp_free;
   } ffra_stat_type;

endpackage

// File: rtl/first_fit_region_allocator.sv
// first-fit region allocator: keeps a sorted table of used regions (start, length) in a
// single-port-write, registered-read ram of MAX_REGIONS entries and serves one request beat
// at a time. an allocate rounds its size up to ALIGN, walks the table from the lowest start
// and places the region in the first gap that fits inside the pool, then opens a slot by
// moving the later entries up one place; a free walks the table for a matching start and
// closes the slot by moving the later entries down. every request yields exactly one
// result beat. with n regions held, an allocate that lands at table position p walks the
// table up to that position and moves the n - p entries at and above it up one place; a
// free walks the table up to its match or to its end. the table walk and the entry moves
// each go one entry at a time through the ram port; early outs (zero size, table full)
// skip both. the result sits in an output register, so the next request beat is taken
// while a result still waits; a result left untaken holds the sequencer in its hand-off
// state and so stalls the request side. csr_wr_data sets the pool size and should only
// be written while no request is in flight; no clearing pass is needed after reset.
module first_fit_region_allocator import ffra_pkg::*; #(
   parameter int unsigned     MAX_REGIONS = FFRA_MAX_REGIONS,
   parameter int unsigned     ALIGN       = FFRA_ALIGN,
   parameter longint unsigned POOL_MAX    = FFRA_POOL_MAX
) (
   input  logic              clock,
   input  logic              reset,
   // request beats
   input  logic              req_valid,
   output logic              req_ready,
   input  ffra_req_type      req_data,
   // result beats
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffra_rsp_type      rsp_data,
   // pool size register
   input  logic              csr_wr_en,
   input  logic [POOL_W-1:0] csr_wr_data
);

   // command and status between sequencer and datapath
   ffra_cmd_type  cmd;
   ffra_stat_type stat;

   // sequencer: capture, size rounding, table walk, entry moves, result hand-off
   ffra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: pool register, region count, cursor, size rounding and the region table
   ffra_dp #(
      .MAX_REGIONS (MAX_REGIONS),
      .ALIGN       (ALIGN),
      .POOL_MAX    (POOL_MAX)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

// File: rtl/ffra_ram.sv
module ffra_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ffra_ctrl.sv
module ffra_ctrl import ffra_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ffra_stat_type stat,
   output ffra_cmd_type  cmd
);

   ctl_state_type state_ff, state_in;
   status_type    code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      code_ff <= code_in;
   end

   always_comb begin
      state_in       = state_ff;
      code_in        = code_ff;
      req_ready      = 1'b0;
      cmd.op         = OP_NONE;
      cmd.rsp_load   = 1'b0;
      cmd.rsp_status = code_ff;
      case (state_ff)
         CTL_IDLE: begin
            // no beat is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.op   = OP_CAPTURE;
               state_in = CTL_CHECK;
            end
         end
         CTL_CHECK: begin
            if (stat.is_free) begin
               cmd.op   = OP_SCAN_START;
               state_in = CTL_SCAN;
            end else if (stat.req_zero) begin
               code_in  = STATUS_ZERO_SIZE;
               state_in = CTL_DONE;
            end else if (stat.table_full) begin
               code_in  = STATUS_TABLE_FULL;
               state_in = CTL_DONE;
            end else begin
               state_in = CTL_SIZE;
            end
         end
         CTL_SIZE: begin
            cmd.op   = OP_SCAN_START;
            state_in = CTL_SCAN;
         end
         CTL_SCAN: begin
            if (stat.is_free) begin
               if (stat.at_end) begin
                  code_in  = STATUS_NOT_FOUND;
                  state_in = CTL_DONE;
               end else if (stat.match) begin
                  cmd.op   = OP_REM_START;
                  state_in = CTL_REMOVE;
               end else begin
                  cmd.op = OP_SCAN_NEXT;
               end
            end else begin
               if (stat.at_end) begin
                  if (stat.end_fit) begin
                     cmd.op   = OP_INS_START;
                     state_in = CTL_INSERT;
                  end else begin
                     code_in  = STATUS_NO_SPACE;
                     state_in = CTL_DONE;
                  end
               end else if (stat.fit) begin
                  cmd.op   = OP_INS_START;
                  state_in = CTL_INSERT;
               end else begin
                  cmd.op = OP_SCAN_NEXT;
               end
            end
         end
         CTL_INSERT: begin
            if (stat.sh_at_pos) begin
               cmd.op   = OP_INS_PLACE;
               code_in  = STATUS_OK;
               state_in = CTL_DONE;
            end else begin
               cmd.op = OP_INS_STEP;
            end
         end
         CTL_REMOVE: begin
            if (stat.sh_at_last) begin
               cmd.op   = OP_REM_DONE;
               code_in  = STATUS_OK;
               state_in = CTL_DONE;
            end else begin
               cmd.op = OP_REM_STEP;
            end
         end
         CTL_DONE: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/ffra_dp.sv
`include "first_fit_region_allocator_assert.svh"

module ffra_dp import ffra_pkg::*; #(
   parameter int unsigned     MAX_REGIONS = FFRA_MAX_REGIONS,
   parameter int unsigned     ALIGN       = FFRA_ALIGN,
   parameter longint unsigned POOL_MAX    = FFRA_POOL_MAX
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [POOL_W-1:0] csr_wr_data,
   input  ffra_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffra_rsp_type      rsp_data,
   input  ffra_cmd_type      cmd,
   output ffra_stat_type     stat
);

   localparam int unsigned     CNT_W       = $clog2(MAX_REGIONS + 1);
   localparam int unsigned     IDX_W       = CNT_W + 1;
   localparam int unsigned     ADDR_W      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int unsigned     ENTRY_W     = 2 * FIELD_W;
   localparam int unsigned     RECIP_SHIFT = SUM_W + $clog2(ALIGN);
   localparam int unsigned     RECIP_W     = RECIP_SHIFT + 1;
   localparam longint unsigned RECIP       = ((64'd1 << RECIP_SHIFT) + ALIGN - 1) / ALIGN;
   localparam int unsigned     PROD_W      = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_V  = RECIP_W'(RECIP);
   localparam logic [SUM_W-1:0]   ALIGN_V  = SUM_W'(ALIGN);
   localparam logic [SUM_W-1:0]   ALIGN_M1 = SUM_W'(ALIGN - 1);
   localparam logic [CNT_W-1:0]   MAX_COUNT = CNT_W'(MAX_REGIONS);
   localparam logic [IDX_W-1:0]   MAX_IDX   = IDX_W'(MAX_REGIONS);
   localparam logic [POOL_W-1:0]  POOL_CAP  =
      POOL_W'((POOL_MAX < FFRA_OFFSET_REACH) ? POOL_MAX : FFRA_OFFSET_REACH);

   ffra_req_type        req_ff, req_in;
   logic [POOL_W-1:0]   pool_ff, pool_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    ev_ff, ev_in;
   logic [CNT_W-1:0]    sh_ff, sh_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CUR_W-1:0]    cursor_ff, cursor_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [SUM_W-1:0]    size_ff, size_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ffra_rsp_type        rsp_data_ff, rsp_data_in;

   logic [SUM_W-1:0]    round_sum;
   logic [SUM_W-1:0]    quot;
   logic [POOL_W-1:0]   pool_use;
   logic [NEED_W-1:0]   need;
   logic [FIELD_W-1:0]  rd_start, rd_len;
   logic [IDX_W-1:0]    rd_idx;
   logic [CNT_W-1:0]    wr_idx;
   logic [ADDR_W-1:0]   ram_raddr, ram_waddr;
   logic                ram_we;
   logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

   ffra_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_REGIONS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // round up by a reciprocal multiply, exact for every 18-bit sum
   assign round_sum = SUM_W'(req_ff.request_size) + ALIGN_M1;
   assign prod_in   = PROD_W'(round_sum) * PROD_W'(RECIP_V);
   assign quot      = prod_ff[RECIP_SHIFT +: SUM_W];
   assign size_in   = quot * ALIGN_V;

   assign pool_use = (pool_ff > POOL_CAP) ? POOL_CAP : pool_ff;
   assign rd_start = ram_rdata[ENTRY_W-1 -: FIELD_W];
   assign rd_len   = ram_rdata[FIELD_W-1:0];
   assign need     = NEED_W'(cursor_ff) + NEED_W'(size_ff);

   always_comb begin
      case (cmd.op)
         OP_SCAN_NEXT: rd_idx = IDX_W'(ev_ff) + IDX_W'(1);
         OP_INS_START: rd_idx = IDX_W'(count_ff) - IDX_W'(1);
         OP_INS_STEP:  rd_idx = IDX_W'(sh_ff) - IDX_W'(2);
         OP_REM_START: rd_idx = IDX_W'(ev_ff) + IDX_W'(1);
         OP_REM_STEP:  rd_idx = IDX_W'(sh_ff) + IDX_W'(2);
         default:      rd_idx = '0;
      endcase
   end

   // reads past either end carry nothing that is used
   assign ram_raddr = (rd_idx < MAX_IDX) ? rd_idx[ADDR_W-1:0] : '0;
   assign wr_idx    = (cmd.op == OP_INS_PLACE) ? pos_ff : sh_ff;
   assign ram_waddr = wr_idx[ADDR_W-1:0];
   assign ram_we    = (cmd.op == OP_INS_STEP) || (cmd.op == OP_REM_STEP) ||
                      (cmd.op == OP_INS_PLACE);
   assign ram_wdata = (cmd.op == OP_INS_PLACE) ?
                      {FIELD_W'(cursor_ff), FIELD_W'(size_ff)} : ram_rdata;

   always_comb begin
      req_in    = req_ff;
      pool_in   = csr_wr_en ? csr_wr_data : pool_ff;
      count_in  = count_ff;
      ev_in     = ev_ff;
      sh_in     = sh_ff;
      pos_in    = pos_ff;
      cursor_in = cursor_ff;
      case (cmd.op)
         OP_CAPTURE: begin
            req_in = req_data;
         end
         OP_SCAN_START: begin
            ev_in     = '0;
            cursor_in = '0;
         end
         OP_SCAN_NEXT: begin
            ev_in     = ev_ff + CNT_W'(1);
            cursor_in = CUR_W'(rd_start) + CUR_W'(rd_len);
         end
         OP_INS_START: begin
            pos_in = ev_ff;
            sh_in  = count_ff;
         end
         OP_INS_STEP: begin
            sh_in = sh_ff - CNT_W'(1);
         end
         OP_INS_PLACE: begin
            count_in = count_ff + CNT_W'(1);
         end
         OP_REM_START: begin
            sh_in = ev_ff;
         end
         OP_REM_STEP: begin
            sh_in = sh_ff + CNT_W'(1);
         end
         OP_REM_DONE: begin
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.status   = cmd.rsp_status;
         rsp_data_in.region_offset =
            ((cmd.rsp_status == STATUS_OK) && (req_ff.mode == MODE_ALLOC)) ?
            cursor_ff[OFFSET_W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= POOL_W'(FFRA_OFFSET_REACH);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pool_ff      <= pool_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      ev_ff       <= ev_in;
      sh_ff       <= sh_in;
      pos_ff      <= pos_in;
      cursor_ff   <= cursor_in;
      prod_ff     <= prod_in;
      size_ff     <= size_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.is_free    = (req_ff.mode == MODE_FREE);
   assign stat.req_zero   = (req_ff.request_size == '0);
   assign stat.table_full = (count_ff == MAX_COUNT);
   assign stat.at_end     = (ev_ff == count_ff);
   assign stat.fit        = (NEED_W'(rd_start) >= need) && (NEED_W'(pool_use) >= need);
   assign stat.end_fit    = (NEED_W'(pool_use) >= need);
   assign stat.match      = (rd_start == FIELD_W'(req_ff.free_offset));
   assign stat.sh_at_pos  = (sh_ff == pos_ff);
   assign stat.sh_at_last = ((IDX_W'(sh_ff) + IDX_W'(1)) == IDX_W'(count_ff));
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FFRA_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= MAX_COUNT, "region count beyond table depth")
   `FFRA_ASSERT_IMPLY(a_place_room, clock, reset, cmd.op == OP_INS_PLACE, count_ff < MAX_COUNT, "insert into a full table")
   `FFRA_ASSERT_IMPLY(a_load_slot, clock, reset, cmd.rsp_load, !rsp_valid_ff || rsp_ready, "result overwrites an untaken beat")
   `FFRA_ASSERT_NEXT(a_load_shows, clock, reset, cmd.rsp_load, rsp_valid_ff, "loaded result not presented")

endmodule
